// ===== hw/rtl/rem_pkg.sv =====
// ----------------------------------------------------------------------------
// rem_pkg
// Shared widths, step counts and controller/datapath interface types for the
// regression error metrics block.
// ----------------------------------------------------------------------------
package rem_pkg;

   localparam int VALUE_BITS = 16;
   localparam int CNT_BITS   = 17;
   localparam int RES_BITS   = 51;
   localparam int SUM_BITS   = 32;
   localparam int SQ_BITS    = 47;
   localparam int MSE_BITS   = 35;
   localparam int RMSE_BITS  = 18;
   localparam int R2_BITS    = 32;

   localparam int PROD_A_BITS = 64;   // n * sum_y2
   localparam int PROD_N_BITS = 68;   // ss_res * n
   localparam int DNUM_BITS   = 84;   // divider numerator
   localparam int DDIV_BITS   = 64;   // divider divisor
   localparam int SRAD_BITS   = 36;   // square root radicand
   localparam int SREM_BITS   = 22;   // square root partial remainder

   localparam logic [CNT_BITS-1:0] MAX_PAIRS = CNT_BITS'(65536);

   localparam int MUL_STEPS  = CNT_BITS;
   localparam int DIV_STEPS  = DNUM_BITS;
   localparam int SQRT_STEPS = SRAD_BITS / 2;
   localparam int STEP_BITS  = 7;

   localparam logic [R2_BITS-1:0] R2_ONE     = R2_BITS'(65536);
   localparam logic [R2_BITS-1:0] R2_SAT     = 32'h8000_0000;
   localparam logic [R2_BITS-1:0] R2_Q_LIMIT = 32'd2147549184;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic acc;        // accumulate the accepted word
      logic mul_load;   // start the shift-add products, latch sum_y^2
      logic mul_step;   // one shift-add step
      logic div_mse;    // load divider with ss_res / n
      logic div_r2;     // load divider with the R2 ratio
      logic div_step;   // one restoring divide step
      logic sqrt_load;  // store mse, load square root
      logic sqrt_step;  // one square root step
      logic out_load;   // load result register and clear accumulators
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic spread;     // n*sum_y2 > sum_y^2
      logic out_full;   // result register occupied and not taken this cycle
   } stat_type;

endpackage

// ===== hw/rtl/rem_ctrl.sv =====
// ----------------------------------------------------------------------------
// rem_ctrl
// Sequencer: accepts words while idle, then steps the multiply, divide and
// square root phases of the datapath at the end of each data set.
// ----------------------------------------------------------------------------
module rem_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tlast,
   output logic              req_tready,
   input  rem_pkg::stat_type stat,
   output rem_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MLOAD = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_DMSE  = 4'd3;
   localparam logic [3:0] S_DIV1  = 4'd4;
   localparam logic [3:0] S_SLOAD = 4'd5;
   localparam logic [3:0] S_SQRT  = 4'd6;
   localparam logic [3:0] S_RLOAD = 4'd7;
   localparam logic [3:0] S_DIV2  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0]                    state_ff, state_in;
   logic [rem_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                          take;

   assign req_tready = (state_ff == S_IDLE);
   assign take       = req_tvalid & req_tready;

   // Next state, step count and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd.acc = 1'b1;
               if (req_tlast) state_in = S_MLOAD;
            end
         end
         S_MLOAD: begin
            cmd.mul_load = 1'b1;
            step_in      = '0;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == rem_pkg::STEP_BITS'(rem_pkg::MUL_STEPS - 1)) state_in = S_DMSE;
         end
         S_DMSE: begin
            cmd.div_mse = 1'b1;
            step_in     = '0;
            state_in    = S_DIV1;
         end
         S_DIV1: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == rem_pkg::STEP_BITS'(rem_pkg::DIV_STEPS - 1)) state_in = S_SLOAD;
         end
         S_SLOAD: begin
            cmd.sqrt_load = 1'b1;
            step_in       = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == rem_pkg::STEP_BITS'(rem_pkg::SQRT_STEPS - 1)) state_in = S_RLOAD;
         end
         S_RLOAD: begin
            step_in = '0;
            if (stat.spread) begin
               cmd.div_r2 = 1'b1;
               state_in   = S_DIV2;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV2: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == rem_pkg::STEP_BITS'(rem_pkg::DIV_STEPS - 1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (!stat.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== hw/rtl/rem_dp.sv =====
// ----------------------------------------------------------------------------
// rem_dp
// Datapath: accumulators, shift-add multiplier, restoring divider, bitwise
// square root and the result register.
// ----------------------------------------------------------------------------
module rem_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  rem_pkg::cmd_type                        cmd,
   output rem_pkg::stat_type                       stat,
   input  logic signed [rem_pkg::VALUE_BITS-1:0]   true_value,
   input  logic signed [rem_pkg::VALUE_BITS-1:0]   pred_value,
   input  logic                                    rsp_tready,
   output logic                                    rsp_valid,
   output logic [rem_pkg::MSE_BITS-1:0]            mse,
   output logic [rem_pkg::RMSE_BITS-1:0]           rmse,
   output logic [rem_pkg::R2_BITS-1:0]             r2,
   output logic [rem_pkg::CNT_BITS-1:0]            pair_count,
   output logic                                    overflow
);

   // Accumulators
   logic [rem_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [rem_pkg::RES_BITS-1:0] res_ff, res_in;
   logic [rem_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [rem_pkg::SQ_BITS-1:0]  sq_ff, sq_in;
   logic                         ovf_ff, ovf_in;

   logic signed [rem_pkg::VALUE_BITS:0]     diff;
   logic signed [2*rem_pkg::VALUE_BITS+1:0] diff_sq;
   logic signed [2*rem_pkg::VALUE_BITS-1:0] true_sq;

   assign diff    = {true_value[rem_pkg::VALUE_BITS-1], true_value}
                  - {pred_value[rem_pkg::VALUE_BITS-1], pred_value};
   assign diff_sq = diff * diff;
   assign true_sq = true_value * true_value;

   // Accumulate a word unless the count is full; clear after a result
   always_comb begin
      cnt_in = cnt_ff;
      res_in = res_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      ovf_in = ovf_ff;
      if (cmd.out_load) begin
         cnt_in = '0;
         res_in = '0;
         sum_in = '0;
         sq_in  = '0;
         ovf_in = 1'b0;
      end else if (cmd.acc) begin
         if (cnt_ff == rem_pkg::MAX_PAIRS) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            res_in = res_ff + rem_pkg::RES_BITS'(unsigned'(diff_sq));
            sum_in = sum_ff + rem_pkg::SUM_BITS'(true_value);
            sq_in  = sq_ff + rem_pkg::SQ_BITS'(unsigned'(true_sq));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         res_ff <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         res_ff <= res_in;
         sum_ff <= sum_in;
         sq_ff  <= sq_in;
         ovf_ff <= ovf_in;
      end
   end

   // Shift-add products by n, MSB first, and sum_y^2 in one multiply
   logic [rem_pkg::PROD_A_BITS-1:0] ma_ff, bq_ff;
   logic [rem_pkg::PROD_N_BITS-1:0] mn_ff;
   logic [rem_pkg::CNT_BITS-1:0]    nsh_ff;
   logic [rem_pkg::SUM_BITS-1:0]    sum_mag;

   assign sum_mag = sum_ff[rem_pkg::SUM_BITS-1] ? (~sum_ff + 1'b1) : sum_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         ma_ff  <= '0;
         mn_ff  <= '0;
         nsh_ff <= cnt_ff;
         bq_ff  <= rem_pkg::PROD_A_BITS'(sum_mag) * rem_pkg::PROD_A_BITS'(sum_mag);
      end else if (cmd.mul_step) begin
         ma_ff  <= {ma_ff[rem_pkg::PROD_A_BITS-2:0], 1'b0}
                 + (nsh_ff[rem_pkg::CNT_BITS-1] ? rem_pkg::PROD_A_BITS'(sq_ff) : '0);
         mn_ff  <= {mn_ff[rem_pkg::PROD_N_BITS-2:0], 1'b0}
                 + (nsh_ff[rem_pkg::CNT_BITS-1] ? rem_pkg::PROD_N_BITS'(res_ff) : '0);
         nsh_ff <= {nsh_ff[rem_pkg::CNT_BITS-2:0], 1'b0};
      end
   end

   assign stat.spread = (ma_ff > bq_ff);

   // Restoring divider, one quotient bit a cycle
   logic [rem_pkg::DNUM_BITS-1:0] dnum_ff, dq_ff;
   logic [rem_pkg::DDIV_BITS:0]   drem_ff, drem_sh;
   logic [rem_pkg::DDIV_BITS-1:0] ddiv_ff;
   logic                          dge;

   assign drem_sh = {drem_ff[rem_pkg::DDIV_BITS-1:0], dnum_ff[rem_pkg::DNUM_BITS-1]};
   assign dge     = (drem_sh >= {1'b0, ddiv_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_mse) begin
         dnum_ff <= rem_pkg::DNUM_BITS'(res_ff);
         ddiv_ff <= rem_pkg::DDIV_BITS'(cnt_ff);
         drem_ff <= '0;
         dq_ff   <= '0;
      end else if (cmd.div_r2) begin
         dnum_ff <= {mn_ff, 16'b0};
         ddiv_ff <= ma_ff - bq_ff;
         drem_ff <= '0;
         dq_ff   <= '0;
      end else if (cmd.div_step) begin
         dnum_ff <= {dnum_ff[rem_pkg::DNUM_BITS-2:0], 1'b0};
         drem_ff <= dge ? (drem_sh - {1'b0, ddiv_ff}) : drem_sh;
         dq_ff   <= {dq_ff[rem_pkg::DNUM_BITS-2:0], dge};
      end
   end

   // Square root, one result bit a cycle
   logic [rem_pkg::MSE_BITS-1:0]  mse_ff;
   logic [rem_pkg::SRAD_BITS-1:0] srad_ff;
   logic [rem_pkg::SREM_BITS-1:0] srem_ff, srem_sh, strial;
   logic [rem_pkg::RMSE_BITS-1:0] sroot_ff;
   logic                          sge;

   assign srem_sh = {srem_ff[rem_pkg::SREM_BITS-3:0], srad_ff[rem_pkg::SRAD_BITS-1 -: 2]};
   assign strial  = rem_pkg::SREM_BITS'({sroot_ff, 2'b01});
   assign sge     = (srem_sh >= strial);

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         mse_ff   <= dq_ff[rem_pkg::MSE_BITS-1:0];
         srad_ff  <= rem_pkg::SRAD_BITS'(dq_ff[rem_pkg::MSE_BITS-1:0]);
         srem_ff  <= '0;
         sroot_ff <= '0;
      end else if (cmd.sqrt_step) begin
         srad_ff  <= {srad_ff[rem_pkg::SRAD_BITS-3:0], 2'b00};
         srem_ff  <= sge ? (srem_sh - strial) : srem_sh;
         sroot_ff <= {sroot_ff[rem_pkg::RMSE_BITS-2:0], sge};
      end
   end

   // Form R2: zero without spread, saturate a large ratio
   logic [rem_pkg::R2_BITS-1:0] r2_val;
   logic                        r2_sat;

   assign r2_sat = (dq_ff[rem_pkg::DNUM_BITS-1:rem_pkg::R2_BITS] != '0)
                || (dq_ff[rem_pkg::R2_BITS-1:0] > rem_pkg::R2_Q_LIMIT);
   assign r2_val = !stat.spread ? '0
                 : r2_sat       ? rem_pkg::R2_SAT
                 : rem_pkg::R2_ONE - dq_ff[rem_pkg::R2_BITS-1:0];

   // Result register
   logic                          out_vld_ff;
   logic [rem_pkg::MSE_BITS-1:0]  out_mse_ff;
   logic [rem_pkg::RMSE_BITS-1:0] out_rmse_ff;
   logic [rem_pkg::R2_BITS-1:0]   out_r2_ff;
   logic [rem_pkg::CNT_BITS-1:0]  out_cnt_ff;
   logic                          out_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_mse_ff  <= mse_ff;
         out_rmse_ff <= sroot_ff;
         out_r2_ff   <= r2_val;
         out_cnt_ff  <= cnt_ff;
         out_ovf_ff  <= ovf_ff;
      end
   end

   assign stat.out_full = out_vld_ff & ~rsp_tready;
   assign rsp_valid     = out_vld_ff;
   assign mse           = out_mse_ff;
   assign rmse          = out_rmse_ff;
   assign r2            = out_r2_ff;
   assign pair_count    = out_cnt_ff;
   assign overflow      = out_ovf_ff;

endmodule

// ===== hw/rtl/regression_error_metrics.sv =====
// ----------------------------------------------------------------------------
// regression_error_metrics
// MSE, RMSE and R2 over a stream of (true, predicted) Q7.8 pairs.
//
//  channel | dir | tdata                         | tuser    | tlast
//  req     | in  | true_value, pred_value        | -        | last
//  rsp     | out | mse, rmse, r2, pair_count     | overflow | -
//
// A pair is taken every cycle while accumulating. A last pair starts the
// finishing sequence (load, 17 shift-add steps, load and 84-step restoring
// divide for the MSE, load and 18 square root steps, R2 select with a load of
// the second 84-step divide, output load); without spread in the true values
// the second divide is skipped. No pair is taken meanwhile, and the output
// load waits while an older result is stalled in the result register.
// The result register lets the next data set start while a result waits.
// Synchronous reset clears the accumulators and the result valid.
// ----------------------------------------------------------------------------
module regression_error_metrics (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // true_value[15:0], pred_value[31:16]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // mse[34:0], rmse[52:35], r2[84:53], pair_count[101:85]
   output logic         rsp_tuser    // overflow
);

   rem_pkg::cmd_type  cmd;
   rem_pkg::stat_type stat;

   logic [rem_pkg::MSE_BITS-1:0]  mse;
   logic [rem_pkg::RMSE_BITS-1:0] rmse;
   logic [rem_pkg::R2_BITS-1:0]   r2;
   logic [rem_pkg::CNT_BITS-1:0]  pair_count;

   rem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rem_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .true_value (req_tdata[15:0]),
      .pred_value (req_tdata[31:16]),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .mse        (mse),
      .rmse       (rmse),
      .r2         (r2),
      .pair_count (pair_count),
      .overflow   (rsp_tuser)
   );

   // Pack the result word
   assign rsp_tdata = {2'b00, pair_count, r2, rmse, mse};

endmodule

// ===== hw/rtl/rem_chk.sv =====
// ----------------------------------------------------------------------------
// rem_chk
// Port checker for regression_error_metrics, bound to the top level.
// ----------------------------------------------------------------------------
module rem_chk (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic         rsp_tuser
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // No result right after reset
   a_rst_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // A finished data set has at least one pair
   a_cnt_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[101:85] != 17'd0)
      else $error("empty data set reported");

   // Overflow only with a full count
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[101:85] == 17'd65536)
      else $error("overflow without full count");

   // R2 never above one
   a_r2_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[84:53]) <= 32'sd65536)
      else $error("r2 above one");

endmodule

bind regression_error_metrics rem_chk u_rem_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/regression_error_metrics_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// regression_error_metrics_checker
// Watches the pair and metric channels, predicts each data set's MSE, RMSE
// and R2 with exact integer arithmetic and compares every result word.
// ----------------------------------------------------------------------------
module regression_error_metrics_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,   // true_value[15:0], pred_value[31:16]
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,   // mse, rmse, r2, pair_count
   input  logic         rsp_tuser,   // overflow
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic [34:0] mse;
      logic [17:0] rmse;
      logic [31:0] r2;
      logic [16:0] pair_count;
      logic        overflow;
   } metrics_type;

   metrics_type  metrics_q[$];
   logic [16:0]  pair_cnt;
   logic [50:0]  res_sum;
   logic [31:0]  y_sum;
   logic [46:0]  y2_sum;
   logic         ovf_seen;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   function automatic logic [17:0] root_of(input logic [34:0] v);
      logic [35:0] r;
      logic [17:0] q;
      begin
         q = 0;
         for (int b = 17; b >= 0; b--) begin
            r = {18'd0, q | (18'd1 << b)};
            if (r * r <= {1'b0, v}) q = q | (18'd1 << b);
         end
         return q;
      end
   endfunction

   // Fold one pair into the running sums; push a prediction on last
   task automatic take_pair(input logic [31:0] d, input logic fin);
      logic signed [63:0] t, p, e;
      logic signed [63:0] sy;
      logic [127:0] a, b, num, q;
      metrics_type m;
      begin
         t = $signed(d[15:0]);
         p = $signed(d[31:16]);
         if (pair_cnt >= 17'd65536) begin
            ovf_seen = 1'b1;
         end else begin
            e = t - p;
            pair_cnt = pair_cnt + 17'd1;
            res_sum = res_sum + 51'(e * e);
            y_sum = y_sum + 32'(t);
            y2_sum = y2_sum + 47'(t * t);
         end
         if (fin) begin
            m.pair_count = pair_cnt;
            m.overflow = ovf_seen;
            m.mse = (pair_cnt != 0) ? 35'(res_sum / pair_cnt) : 35'd0;
            m.rmse = root_of(m.mse);
            sy = $signed(y_sum);
            a = 128'(pair_cnt) * 128'(y2_sum);
            b = 128'(sy < 0 ? -sy : sy);
            b = b * b;
            if (b >= a) begin
               m.r2 = 32'd0;
            end else begin
               num = (128'(res_sum) * 128'(pair_cnt)) << 16;
               q = num / (a - b);
               if (q > 128'd2147549184) m.r2 = 32'h8000_0000;
               else m.r2 = 32'd65536 - q[31:0];
            end
            metrics_q.push_back(m);
            pair_cnt = 0; res_sum = 0; y_sum = 0; y2_sum = 0; ovf_seen = 0;
         end
      end
   endtask

   // Sample both channels at the edge
   always @(posedge clock) begin
      if (reset) begin
         pair_cnt = 0; res_sum = 0; y_sum = 0; y2_sum = 0; ovf_seen = 0;
         fail_count = 0;
         metrics_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (metrics_q.size() == 0) begin
               $display("unexpected result word at %0t", $time);
               fail_count++;
            end else begin
               metrics_type w;
               w = metrics_q.pop_front();
               if (rsp_tdata[34:0] !== w.mse) report("mse", rsp_tdata[34:0], w.mse);
               if (rsp_tdata[52:35] !== w.rmse) report("rmse", rsp_tdata[52:35], w.rmse);
               if (rsp_tdata[84:53] !== w.r2) report("r2", rsp_tdata[84:53], w.r2);
               if (rsp_tdata[101:85] !== w.pair_count)
                  report("pair_count", rsp_tdata[101:85], w.pair_count);
               if (rsp_tuser !== w.overflow) report("overflow", rsp_tuser, w.overflow);
            end
         end
         if (req_tvalid && req_tready) take_pair(req_tdata, req_tlast);
      end
      pending = metrics_q.size();
   end

endmodule

// ===== tb/regression_error_metrics_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// regression_error_metrics_tb
// Drives data sets of (true, predicted) pairs through the metrics block with
// random bursts and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module regression_error_metrics_tb;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [31:0]  req_tdata = 0;   // true_value[15:0], pred_value[31:16]
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [103:0] rsp_tdata;      // mse, rmse, r2, pair_count
   logic         rsp_tuser;      // overflow
   int           fail_count;
   int           pending;
   int           stall_mode = 0;
   int           burst_left = 0;

   always #10 clock = ~clock;

   regression_error_metrics uut (.*);

   regression_error_metrics_checker chk (.*);

   // Receiver stall pattern, with a mode of no stalls
   always @(posedge clock) begin
      if (stall_mode == 0) rsp_tready <= 1'b1;
      else if (stall_mode == 1) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= ($urandom_range(0, 9) == 0);
   end

   // Send one pair; drop valid for a random gap after a burst or a data set
   task automatic send(input logic [15:0] t, input logic [15:0] p, input logic fin);
      begin
         if (burst_left == 0) burst_left = $urandom_range(1, 12);
         burst_left--;
         req_tvalid <= 1'b1;
         req_tdata <= {p, t};
         req_tlast <= fin;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         if (burst_left == 0 || fin) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   endtask

   function automatic logic [15:0] rand_val(input int kind);
      case (kind)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 255) - 128);
         default: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
      endcase
   endfunction

   task automatic wait_drain();
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int len;
      int kind;
      logic [15:0] y;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single pair, extremes, no spread, poor fit, good fit
      send(16'h0000, 16'h0000, 1);
      send(16'h7fff, 16'h8000, 1);
      send(16'h8000, 16'h7fff, 0); send(16'h7fff, 16'h8000, 1);
      send(16'h0100, 16'h0100, 0); send(16'h0100, 16'h0200, 1);
      send(16'h0001, 16'h8000, 0); send(16'h0000, 16'h7fff, 1);
      send(16'h0100, 16'h0101, 0); send(16'h0200, 16'h0200, 0);
      send(16'h0300, 16'h02ff, 1);
      send(16'hffff, 16'h0000, 0); send(16'h0001, 16'hffff, 1);
      wait_drain();

      // Random data sets, mostly short ones
      sent = 0;
      while (sent < 1000) begin
         if ($urandom_range(0, 49) == 0) stall_mode = $urandom_range(0, 2);
         if ($urandom_range(0, 19) == 0) wait_drain();
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         kind = $urandom_range(0, 2);
         y = rand_val(kind);
         for (int i = 0; i < len; i++) begin
            if (kind == 2 && $urandom_range(0, 1) != 0)
               send(y, rand_val(0), i == len - 1);
            else
               send(rand_val(kind), rand_val(kind), i == len - 1);
            sent++;
         end
      end

      wait_drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end

endmodule
